/* sv/drfp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drfp_pkg
// Shared types and constants of the display reply frame parser.
// ----------------------------------------------------------------------------
package drfp_pkg;

   // Frame markers
   localparam logic [7:0] CHAR_S  = 8'h53;  // 'S'
   localparam logic [7:0] CHAR_T  = 8'h54;  // 'T'
   localparam logic [7:0] CHAR_LT = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_GT = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_E  = 8'h45;  // 'E'

   // Trailer: three marker bytes then two ignored CRC bytes
   localparam int unsigned     TRAILER_LEN = 5;
   localparam logic [15:0]     TRAILER_LAST = 16'(TRAILER_LEN - 1);

   // Result kinds
   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // Register file
   localparam int unsigned     CSR_ADDR_W        = 3;
   localparam logic            REG_KNOWN_COMMAND = 1'b0;  // register index
   localparam logic [15:0]     KNOWN_COMMAND_RST = 16'h0002;

   // Front-to-back queue
   localparam int unsigned     QUEUE_DEPTH = 4;
   localparam int unsigned     QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned     QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Result tdata: payload_byte, frame_command, key_value, trailer_ok,
   // command_known, padded to whole bytes
   localparam int unsigned     RSP_FIELDS_W = 8 + 16 + 8 + 1 + 1;
   localparam int unsigned     RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload;
      logic [15:0] command;
      logic [7:0]  key;
      logic        trailer_ok;
   } result_entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage : drfp_pkg
`default_nettype wire

/* sv/drfp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drfp_front
// Byte-wise frame parser: tracks the frame phase and pushes payload and
// frame-end records into the result queue.
// ----------------------------------------------------------------------------
module drfp_front
   import drfp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             byte_valid,
   input  wire logic [7:0]       byte_data,
   output logic                  byte_ready,
   input  wire queue_status_type q_status,
   output logic                  push,
   output result_entry_type      push_entry
);

   typedef enum logic [3:0] {
      PH_HUNT_S,
      PH_HUNT_T,
      PH_HUNT_LT,
      PH_CMD_HI,
      PH_CMD_LO,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_PAYLOAD,
      PH_TRAILER
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [15:0]  count_ff, count_in;
   logic [15:0]  command_ff, command_in;
   logic [15:0]  length_ff, length_in;
   logic [7:0]   key_ff, key_in;
   logic         match_ff, match_in;
   logic         accept;
   logic [15:0]  length_full;
   logic         last_payload;
   logic         trailer_bad;

   assign byte_ready   = !q_status.full;
   assign accept       = byte_valid && byte_ready;
   assign length_full  = {length_ff[15:8], byte_data};
   assign last_payload = ({1'b0, count_ff} + 17'd1) >= {1'b0, length_ff};
   assign trailer_bad  = (count_ff == 16'd0 && byte_data != CHAR_GT) ||
                         (count_ff == 16'd1 && byte_data != CHAR_E)  ||
                         (count_ff == 16'd2 && byte_data != CHAR_T);

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      command_in = command_ff;
      length_in  = length_ff;
      key_in     = key_ff;
      match_in   = match_ff;
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         case (phase_ff)
            PH_HUNT_S: begin
               if (byte_data == CHAR_S) phase_in = PH_HUNT_T;
            end
            PH_HUNT_T: begin
               if (byte_data == CHAR_T) phase_in = PH_HUNT_LT;
            end
            PH_HUNT_LT: begin
               if (byte_data == CHAR_LT) phase_in = PH_CMD_HI;
            end
            PH_CMD_HI: begin
               command_in = {byte_data, 8'h00};
               phase_in   = PH_CMD_LO;
            end
            PH_CMD_LO: begin
               command_in = {command_ff[15:8], byte_data};
               phase_in   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_in = {byte_data, 8'h00};
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = length_full;
               key_in    = 8'h00;
               count_in  = 16'd0;
               match_in  = 1'b1;
               // zero length skips straight to the trailer with key 0
               phase_in  = (length_full == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (last_payload) begin
                  // hold the final byte as the key, do not emit it
                  key_in   = byte_data;
                  count_in = 16'd0;
                  match_in = 1'b1;
                  phase_in = PH_TRAILER;
               end else begin
                  count_in           = count_ff + 16'd1;
                  push               = 1'b1;
                  push_entry.kind    = KIND_PAYLOAD;
                  push_entry.payload = byte_data;
                  push_entry.command = command_ff;
               end
            end
            PH_TRAILER: begin
               if (trailer_bad) match_in = 1'b0;
               if (count_ff < TRAILER_LAST) begin
                  count_in = count_ff + 16'd1;
               end else begin
                  push                  = 1'b1;
                  push_entry.kind       = KIND_FRAME_END;
                  push_entry.command    = command_ff;
                  push_entry.key        = key_ff;
                  push_entry.trailer_ok = match_ff && !trailer_bad;
                  count_in              = 16'd0;
                  phase_in              = PH_HUNT_S;
               end
            end
            default: begin
               phase_in = PH_HUNT_S;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT_S;
         count_ff   <= '0;
         command_ff <= '0;
         length_ff  <= '0;
         key_ff     <= '0;
         match_ff   <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         key_ff     <= key_in;
         match_ff   <= match_in;
      end
   end

endmodule : drfp_front
`default_nettype wire

/* sv/drfp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drfp_queue
// Short first-in first-out queue of result records between parser and
// output stage.
// ----------------------------------------------------------------------------
module drfp_queue
   import drfp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire result_entry_type push_entry,
   input  wire logic             pop,
   output queue_status_type      status,
   output result_entry_type      head
);

   result_entry_type       store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head         = store_ff[rd_ptr_ff];
   assign do_pop       = pop && status.valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) count_in = count_ff + QUEUE_CNT_W'(1);
      if (!push && do_pop) count_in = count_ff - QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule : drfp_queue
`default_nettype wire

/* sv/drfp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// drfp_back
// Output stage: takes records from the queue, tags frame ends against the
// known command code and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module drfp_back
   import drfp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire queue_status_type      q_status,
   input  wire result_entry_type      q_head,
   output logic                       q_pop,
   input  wire logic [15:0]           known_command,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [RSP_DATA_W-1:0]      out_data,
   output logic                       out_kind
);

   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  kind_ff, kind_in;
   logic                  load;
   logic                  known;

   assign load  = q_status.valid && (!valid_ff || out_ready);
   assign q_pop = load;
   assign known = (q_head.kind == KIND_FRAME_END) && (q_head.command == known_command);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      kind_in  = kind_ff;
      if (load) begin
         valid_in = 1'b1;
         kind_in  = q_head.kind;
         data_in  = RSP_DATA_W'({known, q_head.trailer_ok, q_head.key,
                                 q_head.command, q_head.payload});
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      kind_ff <= kind_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_kind  = kind_ff;

endmodule : drfp_back
`default_nettype wire

/* sv/display_reply_frame_parser_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// display_reply_frame_parser_unit
// Parses reply frames from a serial display link into payload and frame-end
// words.
//
// Usage:
//   req_* carries one received byte per word. rsp_* returns a payload byte
//   word (tuser 0) for every payload byte but the last, and a frame-end word
//   (tuser 1) after the fifth trailer byte with command, key, trailer check
//   and a compare against the known command code register (csr_ at 0x0).
//   A byte is taken every cycle while the four-entry result queue has room;
//   a result goes through the queue, then the output register. Marker bytes
//   and header bytes give no result.
//   When the receiver stalls, words collect in the queue and the output
//   register; once the queue is full, req_tready drops and input holds.
//   Reset returns the parser to hunting for 'S', empties the queue and sets
//   the known command code to 0x0002. Write the register only while idle.
// ----------------------------------------------------------------------------
module display_reply_frame_parser_unit
   import drfp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: [7:0] rx_byte
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,
   // rsp_tdata: [7:0] payload_byte, [23:8] frame_command, [31:24] key_value,
   //            [32] trailer_ok, [33] command_known, [39:34] zero
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: [0] item_kind
   output logic                       rsp_tuser,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [15:0]      known_ff;
   logic             csr_write;
   logic             reg_index;
   queue_status_type q_status;
   result_entry_type push_entry;
   result_entry_type q_head;
   logic             push;
   logic             pop;

   // register index is the word address
   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (reg_index == REG_KNOWN_COMMAND) ? {16'h0000, known_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= KNOWN_COMMAND_RST;
      end else if (csr_write && reg_index == REG_KNOWN_COMMAND) begin
         known_ff <= csr_pwdata[15:0];
      end
   end

   drfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .byte_ready (req_tready),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   drfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .status     (q_status),
      .head       (q_head)
   );

   drfp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_head        (q_head),
      .q_pop         (pop),
      .known_command (known_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (rsp_tdata),
      .out_kind      (rsp_tuser)
   );

endmodule : display_reply_frame_parser_unit
`default_nettype wire
